/* hdl/rc_link_frame_decoder_assert.svh */
// Assertion macros for the RC link frame decoder.
// Depends on signals clk and arst_n in the including scope.
`ifndef RC_LINK_FRAME_DECODER_ASSERT_SVH
`define RC_LINK_FRAME_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define RCFD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcfd assertion failed");
`define RCFD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcfd assertion failed");
`else
`define RCFD_ASSERT_NOW(lbl, ante, cons)
`define RCFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/rcfd_pkg.sv */
// Shared constants, types and the CRC-8 step for the RC link frame decoder.
// No dependencies.
package rcfd_pkg;

	localparam int FRAME_STORE_DEPTH = 64;
	localparam int CHANNEL_COUNT     = 16;
	localparam int CHAN_BITS         = 11;
	localparam int DATA_BYTES        = 22;
	localparam int DATA_W            = DATA_BYTES * 8;
	localparam int SH_DEPTH          = DATA_BYTES + 1;

	localparam logic [7:0] SBUS_SYNC     = 8'h0F;
	localparam logic [6:0] SBUS_FRAME    = 7'd25;
	localparam int         FLAG_LOST     = 2;
	localparam int         FLAG_FS       = 3;
	localparam logic [7:0] CRSF_SYNC_A   = 8'hC8;
	localparam logic [7:0] CRSF_SYNC_B   = 8'hEE;
	localparam logic [7:0] CRSF_TYPE_RC  = 8'h16;
	localparam logic [7:0] CRSF_RC_LEN   = 8'd24;
	localparam logic [7:0] CRSF_MIN_LEN  = 8'd2;
	localparam logic [7:0] CRSF_MAX_LEN  = 8'(FRAME_STORE_DEPTH - 2);
	localparam logic [7:0] CRC_POLY      = 8'hD5;

	localparam logic [10:0] CRSF_LO      = 11'd172;
	localparam logic [10:0] CRSF_HI      = 11'd1811;
	localparam logic [20:0] CRSF_ROUND   = 21'd819;
	// floor(x / 1639) == (x * RECIP) >> 32 for every x below 2^21
	localparam logic [21:0] CRSF_RECIP   = 22'd2620481;
	localparam logic [11:0] SBUS_OFFS    = 12'd880;
	localparam logic [11:0] CRSF_OFFS    = 12'd988;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_GAP  = 2'd1;
	localparam logic [1:0] REG_HOLD = 2'd2;

	localparam logic [1:0] KIND_CHANNEL = 2'd0;
	localparam logic [1:0] KIND_STATUS  = 2'd1;
	localparam logic [1:0] KIND_REJECT  = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic              crsf;
		logic              lost;
		logic              fs;
		logic [31:0]       good;
		logic [31:0]       bad;
		logic [DATA_W-1:0] data;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

/* hdl/rcfd_ifs.sv */
// Handshake channel interfaces: line bytes in, results out, register writes.
// Depends on nothing.
interface rcfd_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  line_byte;
	logic [31:0] arrival_time_us;
	modport source (output valid, line_byte, arrival_time_us, input ready);
	modport sink   (input valid, line_byte, arrival_time_us, output ready);
endinterface

interface rcfd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [3:0]  channel_number;
	logic [10:0] channel_raw_value;
	logic [11:0] channel_pulse_us;
	logic        frame_lost_flag;
	logic        failsafe_flag;
	logic [31:0] good_frame_count;
	logic [31:0] bad_frame_count;
	logic        last_of_frame;
	modport source (output valid, result_kind, channel_number, channel_raw_value,
		channel_pulse_us, frame_lost_flag, failsafe_flag, good_frame_count,
		bad_frame_count, last_of_frame, input ready);
	modport sink (input valid, result_kind, channel_number, channel_raw_value,
		channel_pulse_us, frame_lost_flag, failsafe_flag, good_frame_count,
		bad_frame_count, last_of_frame, output ready);
endinterface

interface rcfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [19:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/rcfd_front.sv */
// Front end: config registers, gap timing, SBUS/CRSF framing, CRC and failsafe.
// Depends on rcfd_pkg and rcfd_ifs; pushes finished frame jobs to the queue.
module rcfd_front import rcfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rcfd_byte_if.sink   byte_ch,
	rcfd_cfg_if.sink    cfg_ch,
	input  q_stat_t     q_stat,
	output logic        q_push,
	output job_t        q_job
);

	logic        mode_q;
	logic [15:0] gap_lim_q;
	logic [19:0] hold_q;
	logic [6:0]  fill_q;
	logic [31:0] prev_q;
	logic        pending_q;
	logic [31:0] start_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;
	logic [7:0]  crc_q;
	logic [7:0]  len_q;
	logic [7:0]  type_q;
	logic [7:0]  sh_q [SH_DEPTH];

	logic        accept;
	logic [7:0]  b;
	logic [31:0] gap;
	logic [6:0]  fill_cur;
	logic [6:0]  fill_n;
	logic        do_store;
	logic [7:0]  len_n, type_n, crc_n;
	logic [31:0] good_n, bad_n;
	logic        pending_n;
	logic [31:0] start_n;
	logic [31:0] elapsed;
	logic        fs_now;
	logic        footer_ok;
	logic [DATA_W-1:0] sbus_data, crsf_data;

	// a register write takes the cycle; line bytes wait for it
	assign byte_ch.ready = !q_stat.full && !cfg_ch.valid;
	assign cfg_ch.ready  = 1'b1;
	assign accept        = byte_ch.valid && byte_ch.ready;

	assign b        = mode_q ? byte_ch.line_byte : ~byte_ch.line_byte;
	assign gap      = byte_ch.arrival_time_us - prev_q;
	assign fill_cur = (gap > {16'd0, gap_lim_q}) ? 7'd0 : fill_q;
	assign elapsed  = byte_ch.arrival_time_us - start_q;
	assign fs_now   = pending_q ? (elapsed >= {12'd0, hold_q}) : (hold_q == 20'd0);
	assign footer_ok = (b == 8'd0) || (b[3:0] == 4'h4);

	for (genvar i = 0; i < DATA_BYTES; i++) begin : g_data
		assign sbus_data[8*i +: 8] = sh_q[DATA_BYTES - i];
		assign crsf_data[8*i +: 8] = sh_q[DATA_BYTES - 1 - i];
	end

	always_comb begin
		fill_n    = fill_cur;
		do_store  = 1'b0;
		len_n     = len_q;
		type_n    = type_q;
		crc_n     = crc_q;
		good_n    = good_q;
		bad_n     = bad_q;
		pending_n = pending_q;
		start_n   = start_q;
		q_push    = 1'b0;
		q_job     = '0;
		if (!mode_q) begin
			if (fill_cur == 7'd0) begin
				if (b == SBUS_SYNC) begin
					do_store = 1'b1;
					fill_n   = 7'd1;
				end
			end else begin
				do_store = 1'b1;
				fill_n   = fill_cur + 7'd1;
				if (fill_n == SBUS_FRAME) begin
					fill_n = 7'd0;
					if (footer_ok) begin
						good_n      = good_q + 32'd1;
						q_push      = accept;
						q_job.lost  = sh_q[0][FLAG_LOST];
						q_job.data  = sbus_data;
						if (sh_q[0][FLAG_FS]) begin
							q_job.kind = KIND_STATUS;
							q_job.fs   = fs_now;
							if (!pending_q) begin
								pending_n = 1'b1;
								start_n   = byte_ch.arrival_time_us;
							end
						end else begin
							q_job.kind = KIND_CHANNEL;
							pending_n  = 1'b0;
						end
					end
				end
			end
		end else if (fill_cur != 7'd0 || b == CRSF_SYNC_A || b == CRSF_SYNC_B) begin
			do_store = 1'b1;
			fill_n   = fill_cur + 7'd1;
			if (fill_cur == 7'd1) begin
				len_n = b;
				if (b < CRSF_MIN_LEN || b > CRSF_MAX_LEN) begin
					fill_n     = 7'd0;
					bad_n      = bad_q + 32'd1;
					q_push     = accept;
					q_job.kind = KIND_REJECT;
				end
			end else if (fill_cur >= 7'd2) begin
				if (fill_cur == 7'd2) begin
					type_n = b;
				end
				if ({1'b0, fill_cur} <= len_q) begin
					crc_n = crc8_byte((fill_cur == 7'd2) ? 8'd0 : crc_q, b);
				end
				if ({1'b0, fill_cur} == 8'(len_q + 8'd1)) begin
					fill_n = 7'd0;
					q_push = accept;
					if (len_q == CRSF_RC_LEN && type_q == CRSF_TYPE_RC && crc_q == b) begin
						good_n     = good_q + 32'd1;
						q_job.kind = KIND_CHANNEL;
						q_job.crsf = 1'b1;
						q_job.data = crsf_data;
					end else begin
						bad_n      = bad_q + 32'd1;
						q_job.kind = KIND_REJECT;
					end
				end
			end
		end
		q_job.good = good_n;
		q_job.bad  = bad_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			gap_lim_q <= 16'd500;
			hold_q    <= 20'd100000;
			fill_q    <= '0;
			prev_q    <= '0;
			pending_q <= 1'b0;
			start_q   <= '0;
			good_q    <= '0;
			bad_q     <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.reg_index)
				REG_MODE: begin
					mode_q    <= cfg_ch.wdata[0];
					fill_q    <= '0;
					prev_q    <= '0;
					pending_q <= 1'b0;
					start_q   <= '0;
					good_q    <= '0;
					bad_q     <= '0;
				end
				REG_GAP:  gap_lim_q <= cfg_ch.wdata[15:0];
				REG_HOLD: hold_q    <= cfg_ch.wdata;
				default: ;
			endcase
		end else if (accept) begin
			fill_q    <= fill_n;
			prev_q    <= byte_ch.arrival_time_us;
			pending_q <= pending_n;
			start_q   <= start_n;
			good_q    <= good_n;
			bad_q     <= bad_n;
		end
	end

	// frame bytes, sync byte included, and per-frame CRSF header
	always_ff @(posedge clk) begin
		if (accept && do_store) begin
			sh_q[0] <= b;
			for (int k = 1; k < SH_DEPTH; k++) begin
				sh_q[k] <= sh_q[k-1];
			end
			len_q  <= len_n;
			type_q <= type_n;
			crc_q  <= crc_n;
		end
	end

endmodule

/* hdl/rcfd_queue.sv */
// Two-entry job queue between the framing front end and the result back end.
// Depends on rcfd_pkg.
module rcfd_queue import rcfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t stat
);

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign head       = mem_q[rd_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

endmodule

/* hdl/rcfd_back.sv */
// Back end: expands a frame job into results, unpacking and scaling channels.
// Depends on rcfd_pkg and rcfd_ifs.
module rcfd_back import rcfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  job_t          head,
	input  q_stat_t       q_stat,
	output logic          q_pop,
	rcfd_result_if.source result_ch
);

	logic              busy_q;
	logic [3:0]        ch_q;
	job_t              job_q;
	logic              ovalid_q;
	logic [1:0]        kind_q;
	logic [3:0]        chn_q;
	logic [10:0]       raw_q;
	logic [11:0]       us_q;
	logic              lost_q, fs_q, last_q;
	logic [31:0]       good_q, bad_q;

	logic        advance;
	logic        last;
	logic [10:0] raw, clamped;
	logic [13:0] sbus_x;
	logic [20:0] crsf_x;
	logic [42:0] prod;
	logic [11:0] us;

	assign advance = !ovalid_q || result_ch.ready;
	assign q_pop   = !busy_q && !q_stat.empty;
	assign last    = (job_q.kind != KIND_CHANNEL) || (ch_q == 4'(CHANNEL_COUNT - 1));

	assign raw     = job_q.data[CHAN_BITS-1:0];
	assign clamped = (raw < CRSF_LO) ? CRSF_LO : ((raw > CRSF_HI) ? CRSF_HI : raw);
	assign sbus_x  = {3'd0, raw} * 14'd5 + 14'd4;
	assign crsf_x  = {11'(clamped - CRSF_LO), 10'd0} + CRSF_ROUND;
	assign prod    = {22'd0, crsf_x} * {21'd0, CRSF_RECIP};
	assign us      = job_q.crsf ? (CRSF_OFFS + {1'b0, prod[42:32]})
	                            : (SBUS_OFFS + {1'b0, sbus_x[13:3]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (advance && busy_q && last) begin
				busy_q <= 1'b0;
			end
			if (advance) ovalid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= head;
			ch_q  <= '0;
		end else if (advance && busy_q) begin
			ch_q       <= ch_q + 4'd1;
			job_q.data <= job_q.data >> CHAN_BITS;
		end
		if (advance && busy_q) begin
			kind_q <= job_q.kind;
			lost_q <= job_q.lost;
			fs_q   <= job_q.fs;
			good_q <= job_q.good;
			bad_q  <= job_q.bad;
			last_q <= last;
			if (job_q.kind == KIND_CHANNEL) begin
				chn_q <= ch_q;
				raw_q <= job_q.crsf ? clamped : raw;
				us_q  <= us;
			end else begin
				chn_q <= '0;
				raw_q <= '0;
				us_q  <= '0;
			end
		end
	end

	assign result_ch.valid             = ovalid_q;
	assign result_ch.result_kind       = kind_q;
	assign result_ch.channel_number    = chn_q;
	assign result_ch.channel_raw_value = raw_q;
	assign result_ch.channel_pulse_us  = us_q;
	assign result_ch.frame_lost_flag   = lost_q;
	assign result_ch.failsafe_flag     = fs_q;
	assign result_ch.good_frame_count  = good_q;
	assign result_ch.bad_frame_count   = bad_q;
	assign result_ch.last_of_frame     = last_q;

endmodule

/* hdl/rc_link_frame_decoder.sv */
// RC link frame decoder (SBUS / CRSF) top level.
// Path: a frame-ending byte's job passes the queue, back-end job and output regs.
// Throughput: one byte per cycle while the job queue has room and no register
// write is taken; a channel frame drains as 16 results after a back-end load.
// Reset: arst_n async, clears framing, counters, failsafe state and queue;
// registers return to SBUS, 500 us gap, 100000 us hold.
`include "rc_link_frame_decoder_assert.svh"
module rc_link_frame_decoder import rcfd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rcfd_byte_if.sink     byte_ch,
	rcfd_cfg_if.sink      cfg_ch,
	rcfd_result_if.source result_ch
);

	// front/back decoupling: each CRSF outcome or good SBUS frame becomes one job
	logic    q_push, q_pop;
	job_t    q_job, q_head;
	q_stat_t q_stat;

	// front: timing, framing, CRC, counters; stalls when the queue is full
	// or a register write is being taken
	rcfd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.cfg_ch  (cfg_ch),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_job   (q_job)
	);

	// two-deep queue absorbs a frame outcome while the previous one drains
	rcfd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	// back: one result per cycle while result_ch is ready; output is registered
	rcfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.result_ch (result_ch)
	);

	`RCFD_ASSERT_NOW(a_q_sane, 1'b1, !(q_stat.full && q_stat.empty))
	`RCFD_ASSERT_NOW(a_pop_nonempty, q_pop, !q_stat.empty)
	`RCFD_ASSERT_NEXT(a_push_lands, q_push && q_stat.empty, !q_stat.empty)
	`RCFD_ASSERT_NOW(a_kind_legal, result_ch.valid, result_ch.result_kind <= KIND_REJECT)

endmodule
